// File: hw/rtl/ctxsym_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctxsym_pkg
// Shared widths, register indexes and sizes for the context code to symbol
// splitter.
// ----------------------------------------------------------------------------
package ctxsym_pkg;

   localparam int CODE_WIDTH      = 32;
   localparam int MAX_CONTEXT_LEN = 8;

   localparam int RADIX_W   = 9;
   localparam int LEN_W     = 4;
   localparam int SYMBOL_W  = 8;
   localparam int POS_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int BIT_CNT_W = $clog2(CODE_WIDTH);
   localparam int DIGITS_W  = MAX_CONTEXT_LEN * SYMBOL_W;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(256);
   localparam logic [LEN_W-1:0]   LEN_MIN   = LEN_W'(1);
   localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_CONTEXT_LEN);

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
   localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RADIX   = 2'd0,
      REG_CTX_LEN = 2'd1
   } csr_reg_type;

endpackage : ctxsym_pkg
`default_nettype wire

// File: hw/rtl/context_id_to_symbols.sv
`default_nettype none
// ----------------------------------------------------------------------------
// context_id_to_symbols
// Splits one context code into context_length base-radix symbols, most
// significant first, using a bit-serial restoring divider.
//
// Usage:
//   req channel: one code per word (req_valid / req_stall / req_code).
//   rsp channel: one symbol per word, with its position, a last mark on
//     position zero and an overflow flag (code not below radix^length).
//   csr port: csr_write with csr_index 0 = radix, 1 = context_length; other
//     indexes dropped; written by the user only while idle; the block never checks.
// Timing:
//   the code is divided by radix length-1 times, one quotient bit per cycle;
//   each division is 32 shift steps plus one to store the remainder. The
//   first symbol is shown once the divisions and the ST_TOP step are done,
//   then one symbol per cycle while rsp_stall is low.
//   One code is in flight at a time; req_stall stays high until its last
//   symbol is taken. A stalled rsp word holds its value.
// Reset: radix 2, context_length 1, no word in flight.
// ----------------------------------------------------------------------------
module context_id_to_symbols (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [ctxsym_pkg::CODE_WIDTH-1:0]      req_code,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [ctxsym_pkg::SYMBOL_W-1:0]        rsp_symbol,
   output      logic [ctxsym_pkg::POS_W-1:0]           rsp_position,
   output      logic                                   rsp_last,
   output      logic                                   rsp_overflow,
   input  wire logic                                   csr_write,
   input  wire logic [ctxsym_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ctxsym_pkg::RADIX_W-1:0]         csr_wdata
);
   import ctxsym_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUSH,
      ST_TOP,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [RADIX_W-1:0]      radix_ff, radix_in;
   logic [LEN_W-1:0]        ctx_len_ff, ctx_len_in;
   logic [CODE_WIDTH-1:0]   quot_ff, quot_in;
   logic [SYMBOL_W-1:0]     rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [POS_W-1:0]        divs_left_ff, divs_left_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [DIGITS_W-1:0]     digits_ff, digits_in;
   logic                    ovf_ff, ovf_in;

   logic [RADIX_W-1:0]      radix_c;
   logic [LEN_W-1:0]        len_c;
   logic [POS_W-1:0]        top_pos;
   logic [SYMBOL_W:0]       part;
   logic                    part_ge;
   logic                    req_take;
   logic                    rsp_take;

   // clamp the registers into their legal ranges
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         radix_c = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         radix_c = RADIX_MAX;
      end else begin
         radix_c = radix_ff;
      end
      if (ctx_len_ff < LEN_MIN) begin
         len_c = LEN_MIN;
      end else if (ctx_len_ff > LEN_MAX) begin
         len_c = LEN_MAX;
      end else begin
         len_c = ctx_len_ff;
      end
   end

   assign top_pos  = POS_W'(len_c - LEN_MIN);
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // one restoring division step: partial remainder is at most 9 bits
   assign part    = {rem_ff, quot_ff[CODE_WIDTH-1]};
   assign part_ge = part >= radix_c;

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      ctx_len_in   = ctx_len_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      divs_left_in = divs_left_ff;
      pos_in       = pos_ff;
      digits_in    = digits_ff;
      ovf_in       = ovf_ff;

      if (csr_write) begin
         case (csr_index)
            REG_RADIX:   radix_in   = csr_wdata;
            REG_CTX_LEN: ctx_len_in = csr_wdata[LEN_W-1:0];
            default:     ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               quot_in      = req_code;
               rem_in       = '0;
               bit_cnt_in   = '0;
               divs_left_in = top_pos;
               state_in     = (top_pos == '0) ? ST_TOP : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in     = part_ge ? SYMBOL_W'(part - radix_c) : part[SYMBOL_W-1:0];
            quot_in    = {quot_ff[CODE_WIDTH-2:0], part_ge};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(CODE_WIDTH - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // remainder is the next digit up from the low end
            digits_in    = {digits_ff[DIGITS_W-SYMBOL_W-1:0], rem_ff};
            rem_in       = '0;
            bit_cnt_in   = '0;
            divs_left_in = divs_left_ff - POS_W'(1);
            state_in     = (divs_left_ff == POS_W'(1)) ? ST_TOP : ST_DIVIDE;
         end
         ST_TOP: begin
            // top digit keeps the low byte of what is left
            digits_in = {digits_ff[DIGITS_W-SYMBOL_W-1:0], quot_ff[SYMBOL_W-1:0]};
            ovf_in    = quot_ff >= CODE_WIDTH'(radix_c);
            pos_in    = top_pos;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_take) begin
               digits_in = {{SYMBOL_W{1'b0}}, digits_ff[DIGITS_W-1:SYMBOL_W]};
               pos_in    = pos_ff - POS_W'(1);
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         radix_ff   <= RADIX_RESET;
         ctx_len_ff <= LEN_RESET;
      end else begin
         state_ff   <= state_in;
         radix_ff   <= radix_in;
         ctx_len_ff <= ctx_len_in;
      end
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      divs_left_ff <= divs_left_in;
      pos_ff       <= pos_in;
      digits_ff    <= digits_in;
      ovf_ff       <= ovf_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_EMIT);
   assign rsp_symbol   = digits_ff[SYMBOL_W-1:0];
   assign rsp_position = pos_ff;
   assign rsp_last     = (pos_ff == '0);
   assign rsp_overflow = ovf_ff;

   // positions count down by one within a run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last) |=>
         (rsp_valid && rsp_position == $past(rsp_position) - POS_W'(1)))
      else $error("symbol position did not step down");

   // overflow flag is the same on every word of one code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last) |=> (rsp_overflow == $past(rsp_overflow)))
      else $error("overflow flag changed within a run");

   // no new code is taken while symbols are still pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while output pending");

   // a taken code is never shown as a result in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> !rsp_valid)
      else $error("result shown in the cycle after accept");

   // the partial remainder stays below the radix
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> ({1'b0, rem_ff} < radix_c))
      else $error("division remainder out of range");

endmodule : context_id_to_symbols
`default_nettype wire

// File: test/context_id_to_symbols_tb.sv
// ----------------------------------------------------------------------------
// context_id_to_symbols_tb
// Feeds context codes through several radix and length settings, predicts
// the base-radix symbol words of each accepted code and checks every symbol
// word that leaves the block, with random gaps on both channels.
// ----------------------------------------------------------------------------
module context_id_to_symbols_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctxsym_pkg::*;

   localparam longint unsigned CODE_LIMIT = 64'hFFFF_FFFF;
   localparam int PHASE_ITEMS = 45;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [POS_W-1:0]    position;
      logic                last;
      logic                overflow;
   } symbol_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CODE_WIDTH-1:0] req_code = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SYMBOL_W-1:0]   rsp_symbol;
   logic [POS_W-1:0]      rsp_position;
   logic                  rsp_last;
   logic                  rsp_overflow;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [RADIX_W-1:0]    csr_wdata = '0;

   logic [CODE_WIDTH-1:0] code_queue[$];
   symbol_word_type       symbol_q[$];
   logic [RADIX_W-1:0]    radix_cfg = RADIX_RESET;
   logic [LEN_W-1:0]      ctx_len_cfg = LEN_RESET;
   bit                    steady = 1'b0;
   int                    gap_left = 0;
   int                    stall_left = 0;
   int                    fail_count = 0;

   context_id_to_symbols u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_code     (req_code),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_symbol   (rsp_symbol),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last),
      .rsp_overflow (rsp_overflow),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   // out-of-range settings fold back to the nearest legal one
   function automatic void effective_shape(output int base, output int digits);
      base   = radix_cfg;
      digits = ctx_len_cfg;
      if (base < 2) base = 2;
      if (base > 256) base = 256;
      if (digits < 1) digits = 1;
      if (digits > MAX_CONTEXT_LEN) digits = MAX_CONTEXT_LEN;
   endfunction

   // base**expo, flags a power beyond the widest code
   function automatic longint unsigned radix_power(input int unsigned base,
                                                   input int unsigned expo,
                                                   output bit too_big);
      longint unsigned acc;
      acc     = 1;
      too_big = 1'b0;
      for (int k = 0; k < expo; k++) begin
         if (acc > CODE_LIMIT / base) begin
            too_big = 1'b1;
            return acc;
         end
         acc = acc * base;
      end
      return acc;
   endfunction

   function automatic void predict_symbols(input logic [CODE_WIDTH-1:0] code);
      int              base, digits;
      longint unsigned rest, pw, quot;
      bit              too_big;
      logic            ovf;
      symbol_word_type word;
      effective_shape(base, digits);
      rest = code;
      pw   = radix_power(base, digits, too_big);
      ovf  = !too_big && rest >= pw;
      for (int pos = digits - 1; pos >= 0; pos--) begin
         pw = radix_power(base, pos, too_big);
         if (too_big) begin
            quot = 0;
         end else begin
            quot = rest / pw;
            rest = rest % pw;
         end
         word.symbol   = quot[SYMBOL_W-1:0];
         word.position = pos[POS_W-1:0];
         word.last     = (pos == 0);
         word.overflow = ovf;
         symbol_q.push_back(word);
      end
   endfunction

   function automatic int idle_len();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // mostly codes that fit the current shape, some near the top, some anything
   function automatic logic [CODE_WIDTH-1:0] pick_code();
      int              base, digits;
      longint unsigned pw, raw;
      bit              too_big;
      int unsigned     sel;
      effective_shape(base, digits);
      pw  = radix_power(base, digits, too_big);
      sel = $urandom_range(0, 99);
      raw = $urandom();
      if (too_big || sel >= 85) return raw[CODE_WIDTH-1:0];
      if (sel >= 75) return CODE_WIDTH'(pw - $urandom_range(0, 1));
      return CODE_WIDTH'(raw % pw);
   endfunction

   // driver: one code word at a time, random gap after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_symbols(req_code);
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (code_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_code  <= code_queue.pop_front();
            gap_left  <= steady ? 0 : idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each symbol word, stall at random
   always @(posedge clock) begin : monitor
      symbol_word_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (symbol_q.size() == 0) begin
               $error("unexpected word: symbol %0d position %0d", rsp_symbol, rsp_position);
               fail_count++;
            end else begin
               want = symbol_q.pop_front();
               if (rsp_symbol !== want.symbol) begin
                  $error("symbol: expected %0d, got %0d", want.symbol, rsp_symbol);
                  fail_count++;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_overflow);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= steady ? 0 : idle_len();
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (code_queue.size() != 0 || req_valid || symbol_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [RADIX_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_RADIX) radix_cfg = value;
      else if (idx == REG_CTX_LEN) ctx_len_cfg = value[LEN_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // upper data bits of the length write are don't-care, so randomize them
   task automatic set_shape(input logic [RADIX_W-1:0] radix, input logic [LEN_W-1:0] len);
      wait_drained();
      write_csr(REG_RADIX, radix);
      write_csr(REG_CTX_LEN, {5'($urandom_range(0, 31)), len});
   endtask

   initial begin : stimulus
      logic [RADIX_W-1:0] radix;
      logic [LEN_W-1:0]   len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset shape: one binary digit
      code_queue.push_back(32'd0);
      code_queue.push_back(32'd1);
      code_queue.push_back(32'd2);
      code_queue.push_back(32'hFFFF_FFFF);
      // writes to unknown indexes change nothing
      wait_drained();
      write_csr(REG_SPARE_LO, 9'h1FF);
      write_csr(REG_SPARE_HI, 9'h000);
      code_queue.push_back(32'd3);
      // radix below two and zero length
      set_shape(9'd0, 4'd0);
      code_queue.push_back(32'd1);
      code_queue.push_back(32'd5);
      // full-width radix: radix**4 already beyond any code
      set_shape(9'd256, 4'd4);
      code_queue.push_back(32'hFFFF_FFFF);
      code_queue.push_back(32'h1234_5678);
      // radix above 256 and length above the maximum
      set_shape(9'h1FF, 4'hF);
      code_queue.push_back(32'hFFFF_FFFF);
      code_queue.push_back(32'hDEAD_BEEF);
      set_shape(9'd1, 4'd9);
      code_queue.push_back(32'd255);
      code_queue.push_back(32'd256);
      code_queue.push_back(32'hFFFF_FFFF);
      // oversized top digit
      set_shape(9'd3, 4'd8);
      code_queue.push_back(32'd6560);
      code_queue.push_back(32'd6561);
      code_queue.push_back(32'hFFFF_FFFF);
      // 255**4 fits the code, 255**5 does not
      set_shape(9'd255, 4'd8);
      code_queue.push_back(32'hFFFF_FFFF);
      code_queue.push_back(32'd4228250625);
      code_queue.push_back(32'd0);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               radix = 9'd2;
               len   = 4'd8;
            end
            1: begin
               radix = 9'd256;
               len   = 4'd1;
            end
            default: begin
               radix = ($urandom_range(0, 99) < 15) ? 9'($urandom_range(0, 511))
                                                    : 9'($urandom_range(2, 256));
               len   = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(1, 4))
                                                    : 4'($urandom_range(0, 15));
            end
         endcase
         set_shape(radix, len);
         steady = (p == 2 || p == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the block has drained
            if (n == PHASE_ITEMS / 2) wait_drained();
            code_queue.push_back(pick_code());
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #16_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
